[design/ucb1_bandit_arm_selector_assert.svh]
// Assertion macros for the UCB1 arm selector checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UCB1_BANDIT_ARM_SELECTOR_ASSERT_SVH
`define UCB1_BANDIT_ARM_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define UBS_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("ubs assertion failed");

// Next-cycle implication, checked outside reset
`define UBS_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("ubs assertion failed");

`endif

[design/ubs_pkg.sv]
// Shared constants, types and helper functions of the UCB1 arm selector.
// No dependencies.
package ubs_pkg;

  localparam int MAX_ARMS = 256;
  localparam int ARM_W    = 8;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 32;
  localparam int SCORE_W  = 24;
  localparam int ACT_W    = 9;
  localparam int REW_W    = 16;
  localparam int LN_W     = 21;
  localparam int ROOT_W   = 20;
  localparam int SQX_W    = 40;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_UCB    = 2'd2;
  localparam logic [1:0] OP_MEAN   = 2'd3;

  typedef logic [SCORE_W-1:0] score_t;

  // Saturate a wide unsigned value to Q8.16
  function automatic score_t sat24(input logic [SUM_W:0] v);
    score_t res;
    res = (v > {{(SUM_W+1-SCORE_W){1'b0}}, SCORE_MAX}) ? SCORE_MAX : v[SCORE_W-1:0];
    return res;
  endfunction

endpackage

[design/ubs_ifs.sv]
// Valid/ready channel interfaces for the UCB1 arm selector.
// Depends on ubs_pkg.
interface ubs_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [ubs_pkg::ARM_W-1:0]  arm;
  logic [ubs_pkg::REW_W-1:0]  reward;
  modport source (output valid, op, arm, reward, input ready);
  modport sink   (input valid, op, arm, reward, output ready);
endinterface

interface ubs_out_if;
  logic                         valid;
  logic                         ready;
  logic [ubs_pkg::ARM_W-1:0]    chosen_arm;
  logic [ubs_pkg::SCORE_W-1:0]  score;
  logic                         unplayed;
  modport source (output valid, chosen_arm, score, unplayed, input ready);
  modport sink   (input valid, chosen_arm, score, unplayed, output ready);
endinterface

[design/ubs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on ubs_pkg.
module ubs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ubs_pkg::SUM_W-1:0]  dividend,
  input  logic [ubs_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [ubs_pkg::SUM_W-1:0]  quotient
);
  logic                       busy_r;
  logic                       done_r;
  logic [5:0]                 step_r;
  logic [ubs_pkg::SUM_W-1:0]  dvd_r;
  logic [ubs_pkg::CNT_W-1:0]  dvs_r;
  logic [ubs_pkg::CNT_W-1:0]  rem_r;
  logic [ubs_pkg::CNT_W:0]    shifted;
  logic                       qbit;

  // trial subtract
  assign shifted = {rem_r, dvd_r[ubs_pkg::SUM_W-1]};
  assign qbit    = (shifted >= {1'b0, dvs_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 6'(ubs_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 6'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? 32'(shifted - {1'b0, dvs_r}) : shifted[ubs_pkg::CNT_W-1:0];
      dvd_r <= {dvd_r[ubs_pkg::SUM_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

[design/ubs_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
// Depends on ubs_pkg.
module ubs_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ubs_pkg::SQX_W-1:0]   radicand,
  output logic                        done,
  output logic [ubs_pkg::ROOT_W-1:0]  root
);
  localparam int W = ubs_pkg::SQX_W;

  logic          busy_r;
  logic          done_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  bit_r;
  logic [W-1:0]  trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_r[1:0] != 2'b00)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one step of the digit recurrence per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= {2'b01, {(W-2){1'b0}}};
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ubs_pkg::ROOT_W-1:0];
endmodule

[design/ubs_ln.sv]
// Natural log of the total play count in Q.16: normalise by shifting,
// 16 truncated squarings on a 32x32 multiplier, then one multiply by ln 2.
// Depends on ubs_pkg.
module ubs_ln (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ubs_pkg::CNT_W-1:0] n,
  output logic                      done,
  output logic [ubs_pkg::LN_W-1:0]  ln
);
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_CHK  = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;

  logic [2:0]                  state_r;
  logic                        done_r;
  logic [31:0]                 m_r;
  logic [4:0]                  e_r;
  logic [3:0]                  i_r;
  logic [63:0]                 prod_r;
  logic [ubs_pkg::LN_W-1:0]    res_r;
  logic [ubs_pkg::LN_W+31:0]   lnp_r;
  logic [ubs_pkg::LN_W-1:0]    ln_r;
  logic [32:0]                 m2;

  assign m2 = prod_r[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            if (n <= 32'd1) begin
              done_r <= 1'b1;
            end else begin
              state_r <= L_NORM;
            end
          end
        end
        L_NORM: if (m_r[31]) state_r <= L_SQ;
        L_SQ:   state_r <= L_CHK;
        L_CHK:  state_r <= (i_r == 4'd0) ? L_MUL : L_SQ;
        L_MUL:  state_r <= L_OUT;
        L_OUT: begin
          state_r <= L_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        m_r  <= n;
        e_r  <= 5'd31;
        i_r  <= 4'd15;
        ln_r <= '0;
      end
      L_NORM: begin
        if (m_r[31]) begin
          res_r <= {e_r, 16'd0};
        end else begin
          m_r <= m_r << 1;
          e_r <= e_r - 5'd1;
        end
      end
      L_SQ: prod_r <= m_r * m_r;
      L_CHK: begin
        if (m2[32]) begin
          res_r[i_r] <= 1'b1;
          m_r        <= m2[32:1];
        end else begin
          m_r <= m2[31:0];
        end
        i_r <= i_r - 4'd1;
      end
      L_MUL: lnp_r <= res_r * ubs_pkg::LN2_Q32;
      L_OUT: ln_r  <= lnp_r[ubs_pkg::LN_W+31:32];
      default: ;
    endcase
  end

  assign done = done_r;
  assign ln   = ln_r;
endmodule

[design/ucb1_bandit_arm_selector.sv]
// UCB1 bandit arm selector: sequencer, arm statistics memories and result register.
// Depends on ubs_pkg, ubs_ifs, ubs_div, ubs_sqrt and ubs_ln.
//
// Usage: items enter on in_ch (op, arm, reward) with a valid/ready handshake,
// one result per item leaves on out_ch (chosen_arm, score, unplayed).
// cfg_we/cfg_wdata write active_arms; write it only while the block is idle.
// One item is worked on at a time; in_ch.ready is high only when idle.
// Work per item before its result is offered on out_ch:
//   clear: no arithmetic; update: one division.
//   mean selection: per played arm one division; unplayed arms skip it.
//   UCB selection: ln N first, then per played arm two divisions and
//   a root on the shared units.
// The divider produces one quotient bit per cycle.
// Reset clears all counters through per-arm valid bits at once, sets
// active_arms to 1 and the block is ready in the next cycle.
// A finished result sits in the output register while the next item is
// accepted; if the receiver stalls, the next result waits for the register.
module ucb1_bandit_arm_selector (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ubs_pkg::ACT_W-1:0]  cfg_wdata,
  ubs_in_if.sink                     in_ch,
  ubs_out_if.source                  out_ch
);
  localparam int AW = ubs_pkg::ARM_W;
  localparam int SW = ubs_pkg::SUM_W;
  localparam int CW = ubs_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOG  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_DAT  = 4'd3;
  localparam logic [3:0] S_UDIV = 4'd4;
  localparam logic [3:0] S_DIVM = 4'd5;
  localparam logic [3:0] S_DIVT = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                   state_r;
  logic [ubs_pkg::ACT_W-1:0]    act_r;
  logic [1:0]                   op_r;
  logic [ubs_pkg::REW_W-1:0]    reward_r;
  logic [AW-1:0]                addr_r;
  logic [AW-1:0]                last_r;
  logic [CW-1:0]                total_r;
  logic [ubs_pkg::MAX_ARMS-1:0] vld_r;
  logic [SW-1:0]                sum_mem [ubs_pkg::MAX_ARMS];
  logic [CW-1:0]                cnt_mem [ubs_pkg::MAX_ARMS];
  logic [SW-1:0]                rd_sum_r;
  logic [CW-1:0]                rd_cnt_r;
  logic                         rd_vld_r;
  logic [CW-1:0]                cnt_r;
  logic [SW-1:0]                mean_r;
  logic [ubs_pkg::LN_W-1:0]     ln_r;
  ubs_pkg::score_t              cur_score_r;
  logic                         cur_unpl_r;
  ubs_pkg::score_t              best_r;
  logic [AW-1:0]                best_arm_r;
  logic                         best_unpl_r;
  logic                         out_valid_r;
  logic [AW-1:0]                out_arm_r;
  ubs_pkg::score_t              out_score_r;
  logic                         out_unpl_r;

  logic                         div_start_r;
  logic [SW-1:0]                div_a_r;
  logic [CW-1:0]                div_b_r;
  logic                         div_done;
  logic [SW-1:0]                div_q;
  logic                         sq_start_r;
  logic [ubs_pkg::SQX_W-1:0]    sq_x_r;
  logic                         sq_done;
  logic [ubs_pkg::ROOT_W-1:0]   sq_root;
  logic                         ln_start_r;
  logic                         ln_done;
  logic [ubs_pkg::LN_W-1:0]     ln_val;

  logic                         in_acc;
  logic                         mem_we;
  logic [SW-1:0]                sum_eff;
  logic [CW-1:0]                cnt_eff;
  logic [SW:0]                  sum_add;
  logic [SW-1:0]                wr_sum;
  logic [CW-1:0]                wr_cnt;
  logic [ubs_pkg::ACT_W-1:0]    lim;

  // shared arithmetic units
  ubs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_a_r),
    .divisor(div_b_r), .done(div_done), .quotient(div_q)
  );
  ubs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r), .radicand(sq_x_r),
    .done(sq_done), .root(sq_root)
  );
  ubs_ln u_ln (
    .clk(clk), .rst_n(rst_n), .start(ln_start_r), .n(total_r),
    .done(ln_done), .ln(ln_val)
  );

  assign in_acc = in_ch.valid && (state_r == S_IDLE);

  // statistics of the arm just read; an unwritten arm reads as zero
  assign sum_eff = rd_vld_r ? rd_sum_r : '0;
  assign cnt_eff = rd_vld_r ? rd_cnt_r : '0;
  assign sum_add = {1'b0, sum_eff} + {{(SW+1-ubs_pkg::REW_W){1'b0}}, reward_r};
  assign wr_sum  = sum_add[SW] ? ubs_pkg::SUM_MAX : sum_add[SW-1:0];
  assign wr_cnt  = (cnt_eff == ubs_pkg::CNT_MAX) ? cnt_eff : cnt_eff + 32'd1;
  assign mem_we  = (state_r == S_DAT) && (op_r == ubs_pkg::OP_UPDATE);

  // active arm count limited to 1 .. MAX_ARMS
  always_comb begin
    if (act_r == '0) begin
      lim = 9'd1;
    end else if (act_r > 9'(ubs_pkg::MAX_ARMS)) begin
      lim = 9'(ubs_pkg::MAX_ARMS);
    end else begin
      lim = act_r;
    end
  end

  // arm statistics memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[addr_r] <= wr_sum;
      cnt_mem[addr_r] <= wr_cnt;
    end
    rd_sum_r <= sum_mem[addr_r];
    rd_cnt_r <= cnt_mem[addr_r];
  end

  // per-arm valid bits, cleared by reset and by a clear item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[addr_r];
      if (in_acc && (in_ch.op == ubs_pkg::OP_CLEAR)) begin
        vld_r <= '0;
      end else if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 9'd1;
    end else if (cfg_we) begin
      act_r <= cfg_wdata;
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      ln_start_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      ln_start_r  <= 1'b0;
      // result register: load a finished result, drop one that was taken
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.op)
              ubs_pkg::OP_CLEAR: begin
                total_r <= '0;
                state_r <= S_DONE;
              end
              ubs_pkg::OP_UPDATE: state_r <= S_RD;
              ubs_pkg::OP_UCB: begin
                ln_start_r <= 1'b1;
                state_r    <= S_LOG;
              end
              default: state_r <= S_RD;
            endcase
          end
        end
        S_LOG: if (ln_done) state_r <= S_RD;
        S_RD:  state_r <= S_DAT;
        S_DAT: begin
          if (op_r == ubs_pkg::OP_UPDATE) begin
            if (total_r != ubs_pkg::CNT_MAX) total_r <= total_r + 32'd1;
            div_start_r <= 1'b1;
            state_r     <= S_UDIV;
          end else if (cnt_eff == '0) begin
            state_r <= S_CMP;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= S_DIVM;
          end
        end
        S_UDIV: if (div_done) state_r <= S_DONE;
        S_DIVM: begin
          if (div_done) begin
            if (op_r == ubs_pkg::OP_UCB) begin
              div_start_r <= 1'b1;
              state_r     <= S_DIVT;
            end else begin
              state_r <= S_CMP;
            end
          end
        end
        S_DIVT: begin
          if (div_done) begin
            sq_start_r <= 1'b1;
            state_r    <= S_SQRT;
          end
        end
        S_SQRT: if (sq_done) state_r <= S_CMP;
        S_CMP:  state_r <= (addr_r == last_r) ? S_DONE : S_RD;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r        <= in_ch.op;
          reward_r    <= in_ch.reward;
          addr_r      <= (in_ch.op == ubs_pkg::OP_UPDATE) ? in_ch.arm : '0;
          last_r      <= 8'(lim - 9'd1);
          best_r      <= '0;
          best_arm_r  <= '0;
          best_unpl_r <= 1'b0;
        end
      end
      S_LOG: if (ln_done) ln_r <= ln_val;
      S_DAT: begin
        cnt_r <= cnt_eff;
        if (op_r == ubs_pkg::OP_UPDATE) begin
          div_a_r <= wr_sum;
          div_b_r <= wr_cnt;
        end else if (cnt_eff == '0) begin
          cur_score_r <= ubs_pkg::SCORE_MAX;
          cur_unpl_r  <= 1'b1;
        end else begin
          div_a_r    <= sum_eff;
          div_b_r    <= cnt_eff;
          cur_unpl_r <= 1'b0;
        end
      end
      S_UDIV: begin
        if (div_done) begin
          best_r      <= ubs_pkg::sat24({1'b0, div_q});
          best_arm_r  <= addr_r;
          best_unpl_r <= 1'b0;
        end
      end
      S_DIVM: begin
        if (div_done) begin
          mean_r      <= div_q;
          cur_score_r <= ubs_pkg::sat24({1'b0, div_q});
          div_a_r     <= {{(SW-ubs_pkg::LN_W-1){1'b0}}, ln_r, 1'b0};
          div_b_r     <= cnt_r;
        end
      end
      S_DIVT: if (div_done) sq_x_r <= {div_q[23:0], 16'd0};
      S_SQRT: begin
        if (sq_done) begin
          cur_score_r <= ubs_pkg::sat24({1'b0, mean_r}
                         + {{(SW+1-ubs_pkg::ROOT_W){1'b0}}, sq_root});
        end
      end
      S_CMP: begin
        // strict compare keeps the lowest index on ties
        if ((addr_r == '0) || (cur_score_r > best_r)) begin
          best_r      <= cur_score_r;
          best_arm_r  <= addr_r;
          best_unpl_r <= cur_unpl_r;
        end
        if (addr_r != last_r) addr_r <= addr_r + 8'd1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_arm_r   <= best_arm_r;
          out_score_r <= best_r;
          out_unpl_r  <= best_unpl_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.chosen_arm = out_arm_r;
  assign out_ch.score      = out_score_r;
  assign out_ch.unplayed   = out_unpl_r;
endmodule

[design/ubs_checker.sv]
// Port-level assertions for the UCB1 arm selector, bound to the top level.
// Depends on ubs_pkg and ucb1_bandit_arm_selector_assert.svh.
`include "ucb1_bandit_arm_selector_assert.svh"

module ubs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ubs_pkg::SCORE_W-1:0]  out_score,
  input logic                         out_unplayed
);
  // one item at a time: after an accept the input side is closed
  `UBS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // a never-played arm always carries the top score
  `UBS_ASSERT_NOW(a_unpl_max, out_valid && out_unplayed, out_score == ubs_pkg::SCORE_MAX)
  // a stalled result stays offered
  `UBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind ucb1_bandit_arm_selector ubs_checker u_ubs_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_score(out_ch.score), .out_unplayed(out_ch.unplayed)
);
